// File: hdl/rsv_pkg.sv
// Shared types, constants, coefficient functions and microprogram of the recursive sine VCO.
package rsv_pkg;

   localparam int PHASE_STEPS    = 4096;
   localparam int COEF_FRAC_BITS = 14;
   localparam int PHASE_BITS     = $clog2(PHASE_STEPS);
   localparam int STEP_W         = 11;
   localparam int AMP_W          = 7;
   localparam int SAMPLE_W       = 16;
   localparam int COEF_W         = COEF_FRAC_BITS + 2;
   localparam int MUL_A_W        = AMP_W + 1 + COEF_W;
   localparam int PROD_W         = MUL_A_W + COEF_W;
   localparam int ACC_W          = SAMPLE_W + COEF_W + COEF_FRAC_BITS + 3;
   localparam int TAB_DEPTH      = 2 * PHASE_STEPS;
   localparam int TAB_ADDR_W     = PHASE_BITS + 1;
   localparam int UPC_W          = 3;

   localparam logic [AMP_W-1:0] AMP_RESET = AMP_W'(50);

   typedef logic signed [COEF_W-1:0]   coef_type;
   typedef logic [PHASE_BITS-1:0]      phase_type;
   typedef logic [STEP_W-1:0]          step_type;
   typedef logic signed [SAMPLE_W-1:0] sample_type;
   typedef logic signed [MUL_A_W-1:0]  mul_a_type;
   typedef logic signed [PROD_W-1:0]   prod_type;
   typedef logic signed [ACC_W-1:0]    acc_type;
   typedef logic [TAB_ADDR_W-1:0]      tab_addr_type;
   typedef logic [UPC_W-1:0]           upc_type;

   localparam acc_type SAT_MAX = ACC_W'(32767);
   localparam acc_type SAT_MIN = ACC_W'(-32768);
   localparam acc_type RND_HALF = ACC_W'(1) <<< (2 * COEF_FRAC_BITS - 1);

   // microprogram addresses
   localparam upc_type UPC_IDLE   = 3'd0;
   localparam upc_type UPC_RT_CW  = 3'd1;
   localparam upc_type UPC_RT_SW  = 3'd2;
   localparam upc_type UPC_RT_CP  = 3'd3;
   localparam upc_type UPC_RT_ADD = 3'd4;
   localparam upc_type UPC_RES    = 3'd5;
   localparam upc_type UPC_DONE   = 3'd6;

   typedef enum logic [1:0] {
      SEQ_NEXT,
      SEQ_JUMP,
      SEQ_ACCEPT,
      SEQ_FINISH
   } seq_type;

   typedef enum logic [1:0] {
      ROM_COS_REQ,
      ROM_SIN_STEP,
      ROM_COS_PHASE
   } rom_sel_type;

   typedef enum logic [1:0] {
      MUL_NONE,
      MUL_Y1_COEF,
      MUL_AMP_COEF,
      MUL_TMP_SIN
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_RT_LOAD,
      ACC_RT_ADD,
      ACC_RES_LOAD
   } acc_op_type;

   typedef struct packed {
      seq_type     seq;
      upc_type     target;
      rom_sel_type rom_sel;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        sw_load;
   } uword_type;

   typedef struct packed {
      uword_type word;
      logic      req_ready;
      logic      commit;
   } ctrl_type;

   typedef struct packed {
      logic out_free;
   } status_type;

   function automatic uword_type ucode(upc_type upc);
      uword_type w;
      w = '{seq: SEQ_JUMP, target: UPC_IDLE, rom_sel: ROM_COS_REQ,
            mul_sel: MUL_NONE, acc_op: ACC_HOLD, sw_load: 1'b0};
      case (upc)
         UPC_IDLE: begin
            w.seq    = SEQ_ACCEPT;
            w.target = UPC_RES;
         end
         UPC_RT_CW: begin
            w.seq     = SEQ_NEXT;
            w.rom_sel = ROM_SIN_STEP;
            w.mul_sel = MUL_Y1_COEF;
            w.acc_op  = ACC_RT_LOAD;
         end
         UPC_RT_SW: begin
            w.seq     = SEQ_NEXT;
            w.rom_sel = ROM_COS_PHASE;
            w.sw_load = 1'b1;
         end
         UPC_RT_CP: begin
            w.seq     = SEQ_NEXT;
            w.mul_sel = MUL_AMP_COEF;
         end
         UPC_RT_ADD: begin
            w.seq     = SEQ_JUMP;
            w.target  = UPC_DONE;
            w.mul_sel = MUL_TMP_SIN;
            w.acc_op  = ACC_RT_ADD;
         end
         UPC_RES: begin
            w.seq     = SEQ_NEXT;
            w.mul_sel = MUL_Y1_COEF;
            w.acc_op  = ACC_RES_LOAD;
         end
         UPC_DONE: begin
            w.seq    = SEQ_FINISH;
            w.target = UPC_IDLE;
         end
         default: begin
            w.seq    = SEQ_JUMP;
            w.target = UPC_IDLE;
         end
      endcase
      return w;
   endfunction

   // sine of a 32-bit turn fraction, folded to one quadrant, Q30 Taylor to x^11
   function automatic coef_type sin_turn(logic [31:0] u);
      logic [63:0] one;
      logic [63:0] half_pi;
      logic [63:0] r;
      logic [63:0] t;
      logic [63:0] x2;
      logic [63:0] h;
      logic [63:0] v;
      logic [63:0] mag;
      logic [63:0] lim;
      one     = 64'd1 << 30;
      half_pi = 64'd1686629713;
      r = {34'd0, u[29:0]};
      if (u[30]) begin
         r = one - r;
      end
      t   = (r * half_pi) >> 30;
      x2  = (t * t) >> 30;
      h   = one - x2 / 64'd110;
      h   = one - ((x2 * h) >> 30) / 64'd72;
      h   = one - ((x2 * h) >> 30) / 64'd42;
      h   = one - ((x2 * h) >> 30) / 64'd20;
      h   = one - ((x2 * h) >> 30) / 64'd6;
      v   = (t * h) >> 30;
      mag = (v + (64'd1 << (29 - COEF_FRAC_BITS))) >> (30 - COEF_FRAC_BITS);
      lim = 64'd1 << COEF_FRAC_BITS;
      if (mag > lim) begin
         mag = lim;
      end
      if (u[31]) begin
         mag = -mag;
      end
      return COEF_W'(mag);
   endfunction

   function automatic logic [31:0] turn_of(int idx);
      logic [63:0] wide;
      wide = (64'(idx) << 32) / PHASE_STEPS;
      return wide[31:0];
   endfunction

   function automatic tab_addr_type tab_addr(logic is_cos, phase_type idx);
      return {is_cos, idx};
   endfunction

endpackage

// File: hdl/rsv_coef_rom.sv
// Sine/cosine coefficient table with registered read.
module rsv_coef_rom (
   input  logic                  clock,
   input  rsv_pkg::tab_addr_type addr,
   output rsv_pkg::coef_type     q_ff
);

   rsv_pkg::coef_type tab [rsv_pkg::TAB_DEPTH];

   // lower half sine, upper half cosine
   initial begin
      for (int i = 0; i < rsv_pkg::PHASE_STEPS; i++) begin
         tab[i] = rsv_pkg::sin_turn(rsv_pkg::turn_of(i));
         tab[i + rsv_pkg::PHASE_STEPS] =
            rsv_pkg::sin_turn(rsv_pkg::turn_of(i) + 32'h4000_0000);
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= tab[addr];
   end

endmodule

// File: hdl/rsv_sequencer.sv
// Microprogram counter and control word decode.
module rsv_sequencer (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_retune,
   input  rsv_pkg::status_type status,
   output rsv_pkg::ctrl_type   ctrl
);

   rsv_pkg::upc_type   upc_ff;
   rsv_pkg::upc_type   upc_in;
   rsv_pkg::uword_type word;

   assign word = rsv_pkg::ucode(upc_ff);

   always_comb begin
      ctrl.word      = word;
      ctrl.req_ready = (word.seq == rsv_pkg::SEQ_ACCEPT);
      ctrl.commit    = (word.seq == rsv_pkg::SEQ_FINISH) && status.out_free;
   end

   always_comb begin
      upc_in = upc_ff;
      case (word.seq)
         rsv_pkg::SEQ_NEXT:   upc_in = upc_ff + 1'b1;
         rsv_pkg::SEQ_JUMP:   upc_in = word.target;
         rsv_pkg::SEQ_ACCEPT: begin
            if (req_valid) begin
               upc_in = req_retune ? upc_ff + 1'b1 : word.target;
            end
         end
         rsv_pkg::SEQ_FINISH: begin
            if (status.out_free) begin
               upc_in = word.target;
            end
         end
         default: upc_in = rsv_pkg::UPC_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff <= rsv_pkg::UPC_IDLE;
      end else begin
         upc_ff <= upc_in;
      end
   end

   a_ready_only_idle: assert property (@(posedge clock) disable iff (reset)
      ctrl.req_ready |-> upc_ff == rsv_pkg::UPC_IDLE)
      else $error("ready outside idle step");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && ctrl.req_ready) |=> !ctrl.req_ready)
      else $error("sequencer did not start after accept");

   a_commit_needs_room: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |-> status.out_free)
      else $error("commit while output register full");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      (upc_ff == rsv_pkg::UPC_DONE && !status.out_free) |=> upc_ff == rsv_pkg::UPC_DONE)
      else $error("finish step left while stalled");

endmodule

// File: hdl/rsv_datapath.sv
// Oscillator state, shared multiplier, accumulator, rounding and output register.
module rsv_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  rsv_pkg::ctrl_type        ctrl,
   output rsv_pkg::status_type      status,
   input  logic                     req_valid,
   input  logic                     req_retune,
   input  logic [10:0]              req_freq_step,
   input  logic                     csr_wr_en,
   input  logic [6:0]               csr_wr_data,
   output rsv_pkg::tab_addr_type    rom_addr,
   input  rsv_pkg::coef_type        rom_q,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic signed [15:0]       rsp_sample
);

   logic [rsv_pkg::AMP_W-1:0] amp_ff;
   rsv_pkg::sample_type       y1_ff;
   rsv_pkg::sample_type       y2_ff;
   rsv_pkg::phase_type        phase_ff;
   rsv_pkg::step_type         step_ff;
   rsv_pkg::coef_type         sw_ff;
   rsv_pkg::mul_a_type        tmp_ff;
   rsv_pkg::acc_type          acc_ff;
   rsv_pkg::acc_type          acc_in;
   logic                      rsp_valid_ff;
   rsv_pkg::sample_type       rsp_sample_ff;

   rsv_pkg::step_type         cos_step;
   rsv_pkg::mul_a_type        mul_a;
   rsv_pkg::coef_type         mul_b;
   rsv_pkg::prod_type         prod;
   rsv_pkg::acc_type          rounded;
   rsv_pkg::acc_type          shifted;
   rsv_pkg::sample_type       y_sat;
   logic                      accept;

   assign accept          = req_valid && ctrl.req_ready;
   assign status.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_sample      = rsp_sample_ff;

   always_comb begin
      cos_step = (ctrl.req_ready && req_retune) ? req_freq_step : step_ff;
      case (ctrl.word.rom_sel)
         rsv_pkg::ROM_COS_REQ:
            rom_addr = rsv_pkg::tab_addr(1'b1, rsv_pkg::PHASE_BITS'(cos_step));
         rsv_pkg::ROM_SIN_STEP:
            rom_addr = rsv_pkg::tab_addr(1'b0, rsv_pkg::PHASE_BITS'(step_ff));
         rsv_pkg::ROM_COS_PHASE:
            rom_addr = rsv_pkg::tab_addr(1'b1, phase_ff);
         default:
            rom_addr = rsv_pkg::tab_addr(1'b1, phase_ff);
      endcase
   end

   always_comb begin
      case (ctrl.word.mul_sel)
         rsv_pkg::MUL_Y1_COEF:  mul_a = rsv_pkg::MUL_A_W'(y1_ff);
         rsv_pkg::MUL_AMP_COEF: mul_a = rsv_pkg::MUL_A_W'(signed'({1'b0, amp_ff}));
         rsv_pkg::MUL_TMP_SIN:  mul_a = tmp_ff;
         default:               mul_a = '0;
      endcase
      mul_b = (ctrl.word.mul_sel == rsv_pkg::MUL_TMP_SIN) ? sw_ff : rom_q;
      prod  = rsv_pkg::PROD_W'(mul_a) * rsv_pkg::PROD_W'(mul_b);
   end

   // all paths scaled to 2*COEF_FRAC_BITS extra fraction bits
   always_comb begin
      case (ctrl.word.acc_op)
         rsv_pkg::ACC_RT_LOAD:
            acc_in = rsv_pkg::ACC_W'(prod) <<< rsv_pkg::COEF_FRAC_BITS;
         rsv_pkg::ACC_RT_ADD:
            acc_in = acc_ff + (rsv_pkg::ACC_W'(prod) <<< 8);
         rsv_pkg::ACC_RES_LOAD:
            acc_in = ((rsv_pkg::ACC_W'(prod) <<< 1)
                     - (rsv_pkg::ACC_W'(y2_ff) <<< rsv_pkg::COEF_FRAC_BITS))
                     <<< rsv_pkg::COEF_FRAC_BITS;
         default:
            acc_in = acc_ff;
      endcase
   end

   always_comb begin
      rounded = acc_ff + rsv_pkg::RND_HALF;
      shifted = rounded >>> (2 * rsv_pkg::COEF_FRAC_BITS);
      if (shifted > rsv_pkg::SAT_MAX) begin
         y_sat = rsv_pkg::SAMPLE_W'(rsv_pkg::SAT_MAX);
      end else if (shifted < rsv_pkg::SAT_MIN) begin
         y_sat = rsv_pkg::SAMPLE_W'(rsv_pkg::SAT_MIN);
      end else begin
         y_sat = rsv_pkg::SAMPLE_W'(shifted);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      if (ctrl.word.sw_load) begin
         sw_ff <= rom_q;
      end
      if (ctrl.word.mul_sel == rsv_pkg::MUL_AMP_COEF) begin
         tmp_ff <= rsv_pkg::MUL_A_W'(prod);
      end
      if (ctrl.commit) begin
         rsp_sample_ff <= y_sat;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff       <= rsv_pkg::AMP_RESET;
         y1_ff        <= '0;
         y2_ff        <= '0;
         phase_ff     <= '0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            amp_ff <= csr_wr_data;
         end
         if (accept && req_retune) begin
            step_ff <= req_freq_step;
         end
         if (ctrl.commit) begin
            y2_ff        <= y1_ff;
            y1_ff        <= y_sat;
            phase_ff     <= phase_ff + rsv_pkg::PHASE_BITS'(step_ff);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   a_phase_moves_on_commit: assert property (@(posedge clock) disable iff (reset)
      !ctrl.commit |=> $stable(phase_ff))
      else $error("phase changed without a commit");

   a_commit_shifts_history: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> y2_ff == $past(y1_ff))
      else $error("sample history not shifted");

   a_commit_fills_output: assert property (@(posedge clock) disable iff (reset)
      ctrl.commit |=> rsp_valid_ff && rsp_sample_ff == y1_ff)
      else $error("output register disagrees with feedback");

endmodule

// File: hdl/recursive_sine_vco.sv
// Top level of the recursive sine VCO: sequencer, datapath and coefficient table.
//
// Each accepted req beat is one tick and yields exactly one rsp beat carrying a
// signed Q8.8 sample. req_retune high latches req_freq_step and takes the
// phase-continuous angle-addition update; otherwise the resonator recursion runs
// with the last latched step. csr_wr_en writes the 7-bit amplitude used on retune.
// A microprogram sequences one shared multiplier and the registered table port.
// Steps per beat, counted from one accept to the earliest next accept:
//   resonator tick: table read, multiply, round/saturate
//   retune tick:    three table reads and three dependent multiplies
// rsp_valid rises once the final step commits the result into the output register.
// The result sits in an output register, so the next beat is accepted while
// rsp_valid waits; the sequencer only stalls in its final step when the
// previous result has not been taken. Reset clears the sample history, phase
// and step, sets the amplitude to 50 and drops rsp_valid.
module recursive_sine_vco (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_retune,
   input  logic [10:0]        req_freq_step,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_sample,
   input  logic               csr_wr_en,
   input  logic [6:0]         csr_wr_data
);

   rsv_pkg::ctrl_type     ctrl;
   rsv_pkg::status_type   status;
   rsv_pkg::tab_addr_type rom_addr;
   rsv_pkg::coef_type     rom_q;

   assign req_ready = ctrl.req_ready;

   rsv_sequencer u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_retune (req_retune),
      .status     (status),
      .ctrl       (ctrl)
   );

   rsv_coef_rom u_rom (
      .clock (clock),
      .addr  (rom_addr),
      .q_ff  (rom_q)
   );

   rsv_datapath u_dp (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .status        (status),
      .req_valid     (req_valid),
      .req_retune    (req_retune),
      .req_freq_step (req_freq_step),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .rom_addr      (rom_addr),
      .rom_q         (rom_q),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_sample    (rsp_sample)
   );

endmodule
